// ===== rtl/rdrle_pkg.sv =====
// ----------------------------------------------------------------------------
// rdrle_pkg
// Shared constants, codes and helpers for the RGB565 delta/RLE decoder.
// ----------------------------------------------------------------------------
package rdrle_pkg;

   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 16;
   localparam int RUN_W   = 16;
   localparam int RSP_W   = COLOR_W + RUN_W;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [COLOR_W-1:0] color_type;
   typedef logic [RUN_W-1:0]   run_type;
   typedef logic [1:0]         phase_type;

   // Parse phase codes
   localparam phase_type PH_LEAD   = 2'd0;
   localparam phase_type PH_LIT_HI = 2'd1;
   localparam phase_type PH_CNT_HI = 2'd2;
   localparam phase_type PH_CNT_LO = 2'd3;

   // Bit 5 of a lead byte marks a literal
   localparam int LIT_FLAG_BIT = 5;

   localparam color_type MASK_HI  = 16'h1800;
   localparam color_type MASK_MID = 16'h00e3;
   localparam color_type MASK_LO  = 16'h0003;

   localparam run_type RUN_ONE = 16'd1;

   // Scatter delta byte bits into an XOR mask over the RGB565 word
   function automatic color_type delta_mask(input byte_type b);
      color_type wide;
      wide = {{(COLOR_W-BYTE_W){1'b0}}, b};
      return ((wide << 5) & MASK_HI) | ((wide << 3) & MASK_MID) | (wide & MASK_LO);
   endfunction

endpackage

// ===== rtl/rgb565_delta_rle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// rgb565_delta_rle_decoder_top
// Byte-stream decoder for delta/literal/run coded RGB565 images, one run out.
// ----------------------------------------------------------------------------
// Result: a byte that completes a run shows its result on rsp_* in the cycle
//   after the request is accepted, from the output register.
// Throughput: one byte per cycle while the output slot is free; the only loop is the parse state update.
// The output register frees itself in the same cycle it is taken, so a full
//   result does not stall input as long as the sink keeps rsp_tready high.
// Reset (synchronous, active high) clears parse state and drops rsp_tvalid.
module rgb565_delta_rle_decoder_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rdrle_pkg::BYTE_W-1:0]  req_tdata,  // [7:0] data_byte
   input  logic                          req_tuser,  // [0] image_start
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rdrle_pkg::RSP_W-1:0]   rsp_tdata   // [15:0] pixel_color, [31:16] run_length
);
   import rdrle_pkg::*;

   // Decoder state
   phase_type phase_ff,     phase_in;
   byte_type  pend_lo_ff,   pend_lo_in;
   byte_type  cnt_hi_ff,    cnt_hi_in;
   color_type last_lit_ff,  last_lit_in;
   color_type last_out_ff,  last_out_in;

   // Output register
   logic      rsp_valid_ff, rsp_valid_in;
   color_type rsp_color_ff, rsp_color_in;
   run_type   rsp_run_ff,   rsp_run_in;

   // Effective state after an image_start clear
   phase_type phase_eff;
   byte_type  pend_lo_eff;
   byte_type  cnt_hi_eff;
   color_type last_lit_eff;
   color_type last_out_eff;

   logic      req_acc;
   logic      emit;
   color_type emit_color;
   run_type   emit_run;
   color_type literal;

   // Output slot is free if empty or being drained this cycle
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;

   assign phase_eff    = req_tuser ? PH_LEAD : phase_ff;
   assign pend_lo_eff  = req_tuser ? '0 : pend_lo_ff;
   assign cnt_hi_eff   = req_tuser ? '0 : cnt_hi_ff;
   assign last_lit_eff = req_tuser ? '0 : last_lit_ff;
   assign last_out_eff = req_tuser ? '0 : last_out_ff;

   assign literal = {req_tdata, pend_lo_eff};

   // Parse one byte
   always_comb begin
      phase_in    = phase_eff;
      pend_lo_in  = pend_lo_eff;
      cnt_hi_in   = cnt_hi_eff;
      last_lit_in = last_lit_eff;
      last_out_in = last_out_eff;
      emit        = 1'b0;
      emit_color  = last_out_eff;
      emit_run    = RUN_ONE;
      case (phase_eff)
         PH_LEAD: begin
            if (req_tdata[LIT_FLAG_BIT]) begin
               pend_lo_in = req_tdata;
               phase_in   = PH_LIT_HI;
            end else begin
               // delta against the last literal
               last_out_in = last_lit_eff ^ delta_mask(req_tdata);
               emit        = 1'b1;
               emit_color  = last_out_in;
            end
         end
         PH_LIT_HI: begin
            if (literal == last_lit_eff) begin
               // repeated literal is the run marker; a count follows
               phase_in = PH_CNT_HI;
            end else begin
               last_lit_in = literal;
               last_out_in = literal;
               phase_in    = PH_LEAD;
               emit        = 1'b1;
               emit_color  = literal;
            end
         end
         PH_CNT_HI: begin
            cnt_hi_in = req_tdata;
            phase_in  = PH_CNT_LO;
         end
         PH_CNT_LO: begin
            // big-endian count, zero passes through
            phase_in   = PH_LEAD;
            emit       = 1'b1;
            emit_color = last_out_eff;
            emit_run   = {cnt_hi_eff, req_tdata};
         end
         default: begin
            phase_in = PH_LEAD;
         end
      endcase
   end

   always_comb begin
      rsp_color_in = rsp_color_ff;
      rsp_run_in   = rsp_run_ff;
      if (req_acc) begin
         rsp_valid_in = emit;
         if (emit) begin
            rsp_color_in = emit_color;
            rsp_run_in   = emit_run;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         pend_lo_ff   <= '0;
         cnt_hi_ff    <= '0;
         last_lit_ff  <= '0;
         last_out_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            phase_ff    <= phase_in;
            pend_lo_ff  <= pend_lo_in;
            cnt_hi_ff   <= cnt_hi_in;
            last_lit_ff <= last_lit_in;
            last_out_ff <= last_out_in;
         end
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_color_ff <= rsp_color_in;
      rsp_run_ff   <= rsp_run_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_run_ff, rsp_color_ff};

endmodule

// ===== rtl/rdrle_checker.sv =====
// ----------------------------------------------------------------------------
// rdrle_checker
// Port-level checks for the RGB565 delta/RLE decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rdrle_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [rdrle_pkg::BYTE_W-1:0]  req_tdata,
   input logic                          req_tuser,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rdrle_pkg::RSP_W-1:0]   rsp_tdata
);
   import rdrle_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a new result only follows an accepted byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready))
      else $error("result without accepted byte");

   // an empty output slot never blocks input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // delta byte at image start: state is clear, so color is the bare mask
   a_start_delta: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser && !req_tdata[LIT_FLAG_BIT]
      |=> rsp_tvalid && rsp_tdata[RSP_W-1:COLOR_W] == RUN_ONE
          && rsp_tdata[COLOR_W-1:0] == delta_mask($past(req_tdata)))
      else $error("start delta decoded wrong");

endmodule

bind rgb565_delta_rle_decoder_top rdrle_checker u_rdrle_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
